// ===== rtl/anrtc_pkg.sv =====
package anrtc_pkg;

   localparam int AXES    = 3;
   localparam int NPM     = 5;
   localparam int NPV     = 2 * AXES + 3;
   localparam int NPG     = AXES + 1;
   localparam int WDEPTH  = AXES * AXES * (NPM + NPV) + AXES * NPG;
   localparam int WADDR_W = 8;
   localparam int IBASE   = 0;
   localparam int CBASE   = AXES * AXES * NPM;
   localparam int GBASE   = CBASE + AXES * AXES * NPV;
   localparam int GPHI_N  = NPM + NPV + NPG;

   localparam int DIV_NUM_W = 49;
   localparam int DIV_DEN_W = 33;

   localparam logic signed [31:0] Q_ONE  = 32'sd65536;
   localparam logic signed [33:0] T_GOON = 34'sd6554;
   localparam logic signed [33:0] T_HOLD = 34'sd26214;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_TIME     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_THETA    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_RADIUS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INERTIA  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_CORIOLIS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_GRAVITY  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_STEP   = 3'd7;

   typedef struct packed {
      logic [30:0]        sample_time;
      logic signed [31:0] pos_theta;
      logic signed [31:0] pos_height;
      logic signed [31:0] pos_radius;
      logic signed [31:0] vel_theta;
      logic signed [31:0] vel_height;
      logic signed [31:0] vel_radius;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] torque_theta;
      logic signed [31:0] torque_height;
      logic signed [31:0] torque_radius;
      logic               saturated;
   } rsp_word_type;

   typedef struct packed {
      logic                 start;
      logic                 neg;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quot;
      logic               clip;
   } div_rsp_type;

endpackage

// ===== rtl/anrtc_ram.sv =====
module anrtc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 138,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/anrtc_div.sv =====
module anrtc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  anrtc_pkg::div_req_type div_req,
   output anrtc_pkg::div_rsp_type div_rsp
);

   import anrtc_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic [5:0]           cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;
   logic [DIV_DEN_W-1:0] rem_in;
   logic signed [DIV_NUM_W:0] sq;

   always_comb begin
      trial  = {rem_ff, num_ff[DIV_NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
      sq     = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= div_req.num;
            den_ff  <= div_req.den;
            neg_ff  <= div_req.neg;
            rem_ff  <= '0;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], ge};
            num_ff <= {num_ff[DIV_NUM_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      div_rsp.done = done_ff;
      if (sq > 50'sd2147483647) begin
         div_rsp.quot = 32'sh7fffffff;
         div_rsp.clip = 1'b1;
      end else if (sq < -50'sd2147483648) begin
         div_rsp.quot = 32'sh80000000;
         div_rsp.clip = 1'b1;
      end else begin
         div_rsp.quot = sq[31:0];
         div_rsp.clip = 1'b0;
      end
   end

endmodule

// ===== rtl/adaptive_nn_robot_torque_controller.sv =====
// Adaptive torque controller for a three-axis cylindrical arm, Q16.16.
// req channel: one word per control tick (time, three positions, three
// velocities), taken with req_valid/req_ready. rsp channel: one word per tick
// (three torques and a saturation flag) with rsp_valid/rsp_ready.
// csr channel: register index and data, always ready; write only when idle.
// One tick at a time: six quotients run through a 49-step restoring
// divider, and each of the 138 weights is read, multiplied twice and
// written back through one shared multiplier and the weight RAM.
// req_ready is high only while no tick is in work. A finished word waits in
// the rsp register; a stalled receiver holds the block in its last step
// until the register frees, while the next req word can already be taken
// once the finished word is in the register, before the receiver takes it.
// Reset restores the register defaults, clears desired velocities and
// marks all weights zero through per-entry valid bits (no clearing pass).
module adaptive_nn_robot_torque_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  anrtc_pkg::req_word_type         req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output anrtc_pkg::rsp_word_type         rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [anrtc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                     csr_data
);

   import anrtc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_GOAL, S_REM, S_DIV1, S_DIV2, S_VD,
      S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7,
      S_GPI, S_GPT, S_ROW, S_ROWM, S_W1, S_W2, S_W3, S_RE, S_RE2, S_DONE
   } state_type;

   typedef enum logic [1:0] {G_INERTIA, G_CORIOLIS, G_GRAVITY} grp_type;

   function automatic logic [32:0] sat48(input logic signed [47:0] v);
      if (v > 48'sd2147483647) return {1'b1, 32'h7fffffff};
      else if (v < -48'sd2147483648) return {1'b1, 32'h80000000};
      else return {1'b0, v[31:0]};
   endfunction

   function automatic logic [32:0] rnd(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + 64'sd32768;
      return sat48(s[63:16]);
   endfunction

   function automatic logic signed [47:0] sx48(input logic signed [31:0] x);
      return {{16{x[31]}}, x};
   endfunction

   function automatic logic signed [39:0] sx40(input logic signed [31:0] x);
      return {{8{x[31]}}, x};
   endfunction

   state_type state_ff;
   grp_type   grp_ff;

   logic [30:0]        move_time_ff;
   logic signed [31:0] goal_ff [AXES];
   logic [30:0]        gain_i_ff, gain_c_ff, gain_g_ff, update_step_ff;

   logic [30:0]        t_ff;
   logic signed [31:0] pos_ff [AXES];
   logic signed [31:0] vel_ff [AXES];
   logic signed [31:0] acc_ff [AXES];
   logic signed [31:0] err_ff [AXES];
   logic signed [31:0] vd_ff  [AXES];
   logic signed [31:0] dv_ff  [AXES];
   logic signed [31:0] tau_ff [AXES];
   logic signed [31:0] gphi_ff [GPHI_N];
   logic signed [31:0] pm4_ff, pv7_ff, pv8_ff, tmp_ff, mult_ff, w_ff;
   logic signed [39:0] racc_ff, sum_ff;
   logic signed [63:0] prod_ff;
   logic [32:0]        tl_ff;
   logic               first_ff;
   logic               clip_ff;
   logic [1:0]         i_ff, k_ff, l_ff;
   logic [3:0]         j_ff;
   logic [WADDR_W-1:0] ptr_i_ff, ptr_c_ff, ptr_g_ff, rd_addr_ff;
   logic [WDEPTH-1:0]  valid_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_in;
   logic [32:0]        rnd_res;
   logic signed [31:0] rnd_val;
   logic               flag;
   logic               rd_en, wr_en;
   logic [WADDR_W-1:0] rd_addr, cur_ptr;
   logic [31:0]        rd_data;
   logic signed [31:0] rd_eff;
   logic signed [31:0] phi, gain_sel;
   logic [3:0]         j_last;
   logic [4:0]         gidx;
   logic               rsp_load;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic signed [31:0] pos_i, vel_i, dv_i, goal_i;
   logic signed [33:0] mt34, t34, lim1, lim2, tl34;
   logic               seg1, seg2;
   logic [32:0]        rem_res, inner_res, err_res, vd_res, w_res, racc_res, tau_res;
   logic signed [31:0] rem_val, inner_val, racc_val;
   logic signed [34:0] sn3, mag3;
   logic signed [33:0] sn2, mag2;
   logic signed [47:0] vel2_48;

   anrtc_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_wram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_ptr),
      .wr_data (w_res[31:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   anrtc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign prod_in = mul_a * mul_b;
   assign rnd_res = rnd(prod_ff);
   assign rnd_val = rnd_res[31:0];
   assign rd_eff  = valid_ff[rd_addr_ff] ? rd_data : 32'sd0;

   always_comb begin
      pos_i  = pos_ff[i_ff];
      vel_i  = vel_ff[i_ff];
      dv_i   = dv_ff[i_ff];
      goal_i = first_ff ? goal_ff[i_ff] : 32'sd0;

      mt34 = {3'b000, move_time_ff};
      t34  = {3'b000, t_ff};
      lim1 = mt34 - T_GOON;
      lim2 = {2'b00, move_time_ff, 1'b0} - T_GOON;
      seg1 = t34 < lim1;
      seg2 = t34 < lim2;
      if (seg1) tl34 = mt34 - t34;
      else if (seg2) tl34 = {2'b00, move_time_ff, 1'b0} - t34;
      else tl34 = T_HOLD;

      rem_res  = sat48(sx48(goal_i) - sx48(pos_i));
      rem_val  = rem_res[31:0];
      sn3      = {{3{rem_val[31]}}, rem_val} + {{2{rem_val[31]}}, rem_val, 1'b0};
      mag3     = sn3[34] ? -sn3 : sn3;

      vel2_48   = {{15{vel_i[31]}}, vel_i, 1'b0};
      inner_res = sat48(sx48(div_rsp.quot) - vel2_48);
      inner_val = inner_res[31:0];
      sn2       = {inner_val[31], inner_val, 1'b0};
      mag2      = sn2[33] ? -sn2 : sn2;

      err_res  = sat48(sx48(dv_i) - sx48(vel_i));
      vd_res   = sat48(sx48(vel_i) + sx48(rnd_val));
      w_res    = sat48(sx48(w_ff) + sx48(rnd_val));
      racc_res = sat48({{8{racc_ff[39]}}, racc_ff});
      racc_val = racc_res[31:0];
      tau_res  = sat48({{8{sum_ff[39]}}, sum_ff} + sx48(racc_val));
   end

   always_comb begin
      case (j_ff)
         4'd1:    phi = pos_ff[0];
         4'd2:    phi = pos_ff[1];
         4'd3:    phi = pos_ff[2];
         4'd4:    phi = (grp_ff == G_INERTIA) ? pm4_ff : vel_ff[0];
         4'd5:    phi = vel_ff[1];
         4'd6:    phi = vel_ff[2];
         4'd7:    phi = pv7_ff;
         4'd8:    phi = pv8_ff;
         default: phi = Q_ONE;
      endcase
      case (grp_ff)
         G_INERTIA: begin
            j_last   = 4'(NPM - 1);
            gidx     = 5'(j_ff);
            gain_sel = {1'b0, gain_i_ff};
            cur_ptr  = ptr_i_ff;
         end
         G_CORIOLIS: begin
            j_last   = 4'(NPV - 1);
            gidx     = 5'(NPM) + 5'(j_ff);
            gain_sel = {1'b0, gain_c_ff};
            cur_ptr  = ptr_c_ff;
         end
         default: begin
            j_last   = 4'(NPG - 1);
            gidx     = 5'(NPM + NPV) + 5'(j_ff);
            gain_sel = {1'b0, gain_g_ff};
            cur_ptr  = ptr_g_ff;
         end
      endcase
   end

   always_comb begin
      mul_a   = 32'sd0;
      mul_b   = 32'sd0;
      flag    = 1'b0;
      rd_en   = 1'b0;
      rd_addr = cur_ptr;
      wr_en   = 1'b0;
      div_req = '0;
      div_req.den = tl_ff;
      unique case (state_ff)
         S_REM: begin
            flag          = rem_res[32];
            div_req.start = 1'b1;
            div_req.neg   = sn3[34];
            div_req.num   = {mag3[32:0], 16'd0};
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               flag          = div_rsp.clip | inner_res[32];
               div_req.start = 1'b1;
               div_req.neg   = sn2[33];
               div_req.num   = {mag2[32:0], 16'd0};
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               flag  = div_rsp.clip | err_res[32];
               mul_a = div_rsp.quot;
               mul_b = {1'b0, update_step_ff};
            end
         end
         S_VD: flag = rnd_res[32] | vd_res[32];
         S_F0: begin
            mul_a = pos_ff[2];
            mul_b = pos_ff[2];
         end
         S_F1: begin
            flag  = rnd_res[32];
            mul_a = pos_ff[2];
            mul_b = vel_ff[2];
         end
         S_F2, S_F5, S_F7: flag = rnd_res[32];
         S_F3, S_F6: begin
            mul_a = tmp_ff;
            mul_b = vel_ff[0];
         end
         S_F4: begin
            flag  = rnd_res[32];
            mul_a = pos_ff[2];
            mul_b = vel_ff[0];
         end
         S_GPI: begin
            mul_a = gain_sel;
            mul_b = phi;
         end
         S_GPT: flag = rnd_res[32];
         S_ROW: begin
            rd_en = 1'b1;
            mul_a = err_ff[k_ff];
            mul_b = (grp_ff == G_INERTIA) ? acc_ff[l_ff] : vel_ff[l_ff];
         end
         S_ROWM: flag = (grp_ff != G_GRAVITY) & rnd_res[32];
         S_W1: begin
            mul_a = rd_eff;
            mul_b = phi;
         end
         S_W2: begin
            flag  = rnd_res[32];
            mul_a = gphi_ff[gidx];
            mul_b = mult_ff;
         end
         S_W3: begin
            flag    = rnd_res[32] | w_res[32];
            wr_en   = 1'b1;
            rd_en   = (j_ff != j_last);
            rd_addr = WADDR_W'(cur_ptr + 1'b1);
         end
         S_RE: begin
            flag = racc_res[32];
            if (grp_ff == G_GRAVITY) begin
               flag = racc_res[32] | tau_res[32];
            end else begin
               mul_a = racc_val;
               mul_b = (grp_ff == G_INERTIA) ? acc_ff[l_ff] : vd_ff[l_ff];
            end
         end
         S_RE2: flag = rnd_res[32];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         valid_ff       <= '0;
         move_time_ff   <= 31'd655360;
         goal_ff[0]     <= 32'sd411775;
         goal_ff[1]     <= 32'sd183501;
         goal_ff[2]     <= 32'sd117965;
         gain_i_ff      <= 31'd164;
         gain_c_ff      <= 31'd164;
         gain_g_ff      <= 31'd32768;
         update_step_ff <= 31'd3277;
         for (int a = 0; a < AXES; a++) begin
            dv_ff[a] <= 32'sd0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MOVE_TIME:     move_time_ff   <= csr_data[30:0];
               CSR_GOAL_THETA:    goal_ff[0]     <= csr_data;
               CSR_GOAL_HEIGHT:   goal_ff[1]     <= csr_data;
               CSR_GOAL_RADIUS:   goal_ff[2]     <= csr_data;
               CSR_GAIN_INERTIA:  gain_i_ff      <= csr_data[30:0];
               CSR_GAIN_CORIOLIS: gain_c_ff      <= csr_data[30:0];
               CSR_GAIN_GRAVITY:  gain_g_ff      <= csr_data[30:0];
               CSR_UPDATE_STEP:   update_step_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         rsp_valid_ff <= rsp_load | (rsp_valid_ff & ~rsp_ready);
         if (wr_en) begin
            valid_ff[cur_ptr] <= 1'b1;
         end
         if (rd_en) begin
            rd_addr_ff <= rd_addr;
         end
         prod_ff <= prod_in;
         clip_ff <= (state_ff != S_IDLE) & (clip_ff | flag);

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  t_ff      <= req_word.sample_time;
                  pos_ff[0] <= req_word.pos_theta;
                  pos_ff[1] <= req_word.pos_height;
                  pos_ff[2] <= req_word.pos_radius;
                  vel_ff[0] <= req_word.vel_theta;
                  vel_ff[1] <= req_word.vel_height;
                  vel_ff[2] <= req_word.vel_radius;
                  state_ff  <= S_GOAL;
               end
            end
            S_GOAL: begin
               tl_ff    <= tl34[32:0];
               first_ff <= seg1;
               i_ff     <= '0;
               state_ff <= S_REM;
            end
            S_REM: state_ff <= S_DIV1;
            S_DIV1: begin
               if (div_rsp.done) state_ff <= S_DIV2;
            end
            S_DIV2: begin
               if (div_rsp.done) begin
                  acc_ff[i_ff] <= div_rsp.quot;
                  err_ff[i_ff] <= err_res[31:0];
                  state_ff     <= S_VD;
               end
            end
            S_VD: begin
               vd_ff[i_ff] <= vd_res[31:0];
               dv_ff[i_ff] <= vd_res[31:0];
               if (i_ff == 2'(AXES - 1)) begin
                  state_ff <= S_F0;
               end else begin
                  i_ff     <= i_ff + 2'd1;
                  state_ff <= S_REM;
               end
            end
            S_F0: state_ff <= S_F1;
            S_F1: begin
               pm4_ff   <= rnd_val;
               state_ff <= S_F2;
            end
            S_F2: begin
               tmp_ff   <= rnd_val;
               state_ff <= S_F3;
            end
            S_F3: state_ff <= S_F4;
            S_F4: begin
               pv7_ff   <= rnd_val;
               state_ff <= S_F5;
            end
            S_F5: begin
               tmp_ff   <= rnd_val;
               state_ff <= S_F6;
            end
            S_F6: state_ff <= S_F7;
            S_F7: begin
               pv8_ff   <= rnd_val;
               grp_ff   <= G_INERTIA;
               j_ff     <= '0;
               state_ff <= S_GPI;
            end
            S_GPI: state_ff <= S_GPT;
            S_GPT: begin
               gphi_ff[gidx] <= rnd_val;
               state_ff      <= S_GPI;
               if (j_ff == j_last) begin
                  j_ff <= '0;
                  unique case (grp_ff)
                     G_INERTIA:  grp_ff <= G_CORIOLIS;
                     G_CORIOLIS: grp_ff <= G_GRAVITY;
                     default: begin
                        grp_ff   <= G_INERTIA;
                        k_ff     <= '0;
                        l_ff     <= '0;
                        ptr_i_ff <= WADDR_W'(IBASE);
                        ptr_c_ff <= WADDR_W'(CBASE);
                        ptr_g_ff <= WADDR_W'(GBASE);
                        sum_ff   <= '0;
                        state_ff <= S_ROW;
                     end
                  endcase
               end else begin
                  j_ff <= j_ff + 4'd1;
               end
            end
            S_ROW: begin
               racc_ff  <= '0;
               j_ff     <= '0;
               state_ff <= S_ROWM;
            end
            S_ROWM: begin
               mult_ff  <= (grp_ff == G_GRAVITY) ? err_ff[k_ff] : rnd_val;
               state_ff <= S_W1;
            end
            S_W1: begin
               w_ff     <= rd_eff;
               state_ff <= S_W2;
            end
            S_W2: begin
               racc_ff  <= racc_ff + sx40(rnd_val);
               state_ff <= S_W3;
            end
            S_W3: begin
               unique case (grp_ff)
                  G_INERTIA:  ptr_i_ff <= ptr_i_ff + 1'b1;
                  G_CORIOLIS: ptr_c_ff <= ptr_c_ff + 1'b1;
                  default:    ptr_g_ff <= ptr_g_ff + 1'b1;
               endcase
               if (j_ff == j_last) begin
                  state_ff <= S_RE;
               end else begin
                  j_ff     <= j_ff + 4'd1;
                  state_ff <= S_W1;
               end
            end
            S_RE: begin
               if (grp_ff == G_GRAVITY) begin
                  tau_ff[k_ff] <= tau_res[31:0];
                  sum_ff       <= '0;
                  if (k_ff == 2'(AXES - 1)) begin
                     state_ff <= S_DONE;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     l_ff     <= '0;
                     grp_ff   <= G_INERTIA;
                     state_ff <= S_ROW;
                  end
               end else begin
                  state_ff <= S_RE2;
               end
            end
            S_RE2: begin
               sum_ff   <= sum_ff + sx40(rnd_val);
               state_ff <= S_ROW;
               if (grp_ff == G_INERTIA) begin
                  grp_ff <= G_CORIOLIS;
               end else if (l_ff == 2'(AXES - 1)) begin
                  grp_ff <= G_GRAVITY;
                  l_ff   <= '0;
               end else begin
                  grp_ff <= G_INERTIA;
                  l_ff   <= l_ff + 2'd1;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_word_ff.torque_theta  <= tau_ff[0];
                  rsp_word_ff.torque_height <= tau_ff[1];
                  rsp_word_ff.torque_radius <= tau_ff[2];
                  rsp_word_ff.saturated     <= clip_ff;
                  state_ff                  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
